@@ rtl/jetp_pkg.sv @@
package jetp_pkg;

	// build-time defaults
	localparam int DEF_MAX_DIM    = 4096;
	localparam int DEF_FRAC_BITS  = 58;
	localparam int DEF_PASS_COUNT = 6;

	// fixed field and port widths
	localparam int WORD_W  = 64;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 3;
	localparam int PASS_W  = 3;
	localparam int COUNT_W = 8;

	// iteration limit is LIMIT_BASE << pass
	localparam int LIMIT_BASE = 6;

	// register indexes
	localparam logic [IDX_W-1:0] REG_CENTER_REAL  = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_IMAG  = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP_SCALE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
	localparam logic [IDX_W-1:0] REG_JULIA_REAL   = 3'd5;
	localparam logic [IDX_W-1:0] REG_JULIA_IMAG   = 3'd6;

	// reset values
	localparam logic [WORD_W-1:0] RST_CENTER_REAL  = 64'd0;
	localparam logic [WORD_W-1:0] RST_CENTER_IMAG  = 64'd0;
	localparam logic [WORD_W-2:0] RST_STEP_SCALE   = 63'd1125899906842624;
	localparam int                RST_IMAGE_WIDTH  = 1024;
	localparam int                RST_IMAGE_HEIGHT = 768;
	localparam logic [WORD_W-1:0] RST_JULIA_REAL   = 64'd82145657203237847;
	localparam logic [WORD_W-1:0] RST_JULIA_IMAG   = 64'd2882303761517117;

	localparam logic [WORD_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

endpackage

@@ rtl/julia_escape_time_pixel.sv @@
// Julia set escape-time engine for one pixel at a time. A request carries the pixel column,
// row and refinement pass; the block forms the start point from the view center and the
// pixel step, then iterates z = z*z + c in 64-bit fixed point (FRAC_BITS fraction bits,
// saturating) while |z|^2 <= 4 and the count is below 6 << pass. The result echoes the
// pixel and gives the count and an escaped flag. All products go through one 32x32
// multiplier, four partial products per 64-bit product; with the default PASS_COUNT the
// iteration limit is at most 192. The block takes one request at a time; a finished result
// waits in the output register while the next request is taken. The user must write the
// configuration registers only while no pixel is in flight; the block does not enforce it.
module julia_escape_time_pixel #(
	parameter int MAX_DIM    = jetp_pkg::DEF_MAX_DIM,
	parameter int FRAC_BITS  = jetp_pkg::DEF_FRAC_BITS,
	parameter int PASS_COUNT = jetp_pkg::DEF_PASS_COUNT,
	localparam int CW = $clog2(MAX_DIM),
	localparam int IW = ((2 * CW + jetp_pkg::PASS_W + 7) / 8) * 8,
	localparam int OW = ((2 * CW + jetp_pkg::COUNT_W + 1 + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [jetp_pkg::IDX_W-1:0]   wr_index,
	input  logic [jetp_pkg::CFG_W-1:0]   wr_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pixel_column, pixel_row, pass_index, zero fill
	input  logic [IW-1:0]                s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_column, out_row, escape_count, escaped, zero fill
	output logic [OW-1:0]                m_tdata
);
	import jetp_pkg::*;

	localparam int SW    = CW + 1;
	localparam int DW    = CW + 2;
	localparam int PCW   = PASS_W + 1;
	localparam int CNT_W = $clog2((LIMIT_BASE << (PASS_COUNT - 1)) + 1);
	localparam int PADW  = OW - (2 * CW + COUNT_W + 1);
	localparam logic [127:0] BOUND = 128'(1) << (2 * FRAC_BITS + 2);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_NEG, S_SSAT, S_ABS, S_SAVE, S_TEST, S_POST2, S_POST3, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		P_SX, P_SY, P_XX, P_YY, P_XY
	} prod_t;

	// configuration
	logic [WORD_W-1:0] center_real_q, center_imag_q, julia_real_q, julia_imag_q;
	logic [WORD_W-2:0] step_scale_q;
	logic [SW-1:0]     image_width_q, image_height_q;

	// sequencer and datapath
	state_t            state_q;
	prod_t             prod_q;
	logic [2:0]        k_q;
	logic [63:0]       pp_q;
	logic [1:0]        pp_sh_q;
	logic              pv_q;
	logic [127:0]      acc_q;
	logic [127:0]      x2_q;
	logic              neg_q;
	logic [DW-1:0]     adx_q, ady_q;
	logic              sdy_q;
	logic [WORD_W-1:0] x_q, y_q, ax_q, ay_q, tx_q, ty_q;
	logic              sxy_q;
	logic [CNT_W-1:0]  cnt_q, limit_q;
	logic [CW-1:0]     col_q, row_q;

	// output register
	logic              out_v_q;
	logic [CW-1:0]     oc_q, or_q;
	logic [COUNT_W-1:0] ocnt_q;
	logic              oesc_q;
	logic              out_load;

	// input fields
	logic [CW-1:0]     in_col, in_row;
	logic [PASS_W-1:0] in_pass;
	logic [PCW-1:0]    pass_c;
	logic [DW-1:0]     dx_c, dy_c;

	// multiplier and adders
	logic [63:0]       op_a, op_b;
	logic [31:0]       a_half, b_half;
	logic [63:0]       pp_c;
	logic [127:0]      pp_ext;
	logic [127:0]      m_c;
	logic [127:0]      accn_c;
	logic [WORD_W-1:0] tx_c, ty_c, ts_c;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	function automatic logic [WORD_W-1:0] sat64(input logic [127:0] v);
		logic [64:0] top;
		top = v[127:63];
		if (top == {65{v[127]}})
			return v[63:0];
		return v[127] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic [WORD_W-1:0] sadd(input logic [WORD_W-1:0] a,
						   input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			return a[63] ? SAT_MIN : SAT_MAX;
		return r;
	endfunction

	assign in_col  = s_tdata[CW-1:0];
	assign in_row  = s_tdata[2*CW-1:CW];
	assign in_pass = s_tdata[2*CW+PASS_W-1:2*CW];

	always_comb begin
		pass_c = {1'b0, in_pass};
		if (pass_c >= PCW'(PASS_COUNT))
			pass_c = PCW'(PASS_COUNT - 1);
	end

	assign dx_c = {2'b00, in_col} - {2'b00, image_width_q[SW-1:1]};
	assign dy_c = {2'b00, in_row} - {2'b00, image_height_q[SW-1:1]};

	always_comb begin
		case (prod_q)
			P_SX: begin
				op_a = {{(64-DW){1'b0}}, adx_q};
				op_b = {1'b0, step_scale_q};
			end
			P_SY: begin
				op_a = {{(64-DW){1'b0}}, ady_q};
				op_b = {1'b0, step_scale_q};
			end
			P_XX: begin
				op_a = ax_q;
				op_b = ax_q;
			end
			P_YY: begin
				op_a = ay_q;
				op_b = ay_q;
			end
			P_XY: begin
				op_a = ax_q;
				op_b = ay_q;
			end
			default: begin
				op_a = ax_q;
				op_b = ay_q;
			end
		endcase
	end

	assign a_half = k_q[0] ? op_a[63:32] : op_a[31:0];
	assign b_half = k_q[1] ? op_b[63:32] : op_b[31:0];
	assign pp_c   = {32'd0, a_half} * {32'd0, b_half};

	always_comb begin
		case (pp_sh_q)
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			2'd2:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = {64'd0, pp_q};
		endcase
	end

	assign m_c    = x2_q + acc_q;
	assign accn_c = neg_q ? (~acc_q + 128'd1) : acc_q;
	assign tx_c   = sat64(128'($signed(x2_q) >>> FRAC_BITS));
	assign ty_c   = sat64(128'($signed(acc_q) >>> (FRAC_BITS - 1)));
	assign ts_c   = sat64(acc_q);

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

	// load the result once the output register is free
	assign out_load = (state_q == S_DONE) && (!out_v_q || m_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_real_q  <= RST_CENTER_REAL;
			center_imag_q  <= RST_CENTER_IMAG;
			step_scale_q   <= RST_STEP_SCALE;
			image_width_q  <= SW'(RST_IMAGE_WIDTH);
			image_height_q <= SW'(RST_IMAGE_HEIGHT);
			julia_real_q   <= RST_JULIA_REAL;
			julia_imag_q   <= RST_JULIA_IMAG;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_REAL:  center_real_q  <= wr_data;
				REG_CENTER_IMAG:  center_imag_q  <= wr_data;
				REG_STEP_SCALE:   step_scale_q   <= wr_data[WORD_W-2:0];
				REG_IMAGE_WIDTH:  image_width_q  <= wr_data[SW-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= wr_data[SW-1:0];
				REG_JULIA_REAL:   julia_real_q   <= wr_data;
				REG_JULIA_IMAG:   julia_imag_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prod_q  <= P_SX;
			k_q     <= 3'd0;
			pv_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						col_q   <= in_col;
						row_q   <= in_row;
						limit_q <= CNT_W'(LIMIT_BASE) << pass_c;
						cnt_q   <= '0;
						adx_q   <= dx_c[DW-1] ? (~dx_c + DW'(1)) : dx_c;
						ady_q   <= dy_c[DW-1] ? (~dy_c + DW'(1)) : dy_c;
						sdy_q   <= dy_c[DW-1];
						neg_q   <= dx_c[DW-1];
						prod_q  <= P_SX;
						k_q     <= 3'd0;
						pv_q    <= 1'b0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// issue partial k, accumulate partial k-1
					if (k_q != 3'd4) begin
						pp_q    <= pp_c;
						pp_sh_q <= {1'b0, k_q[0]} + {1'b0, k_q[1]};
						pv_q    <= 1'b1;
						k_q     <= k_q + 3'd1;
					end else begin
						pv_q <= 1'b0;
					end
					if (pv_q)
						acc_q <= acc_q + pp_ext;
					if (k_q == 3'd4) begin
						case (prod_q)
							P_XX:    state_q <= S_SAVE;
							P_YY:    state_q <= S_TEST;
							default: state_q <= S_NEG;
						endcase
					end
				end
				S_NEG: begin
					acc_q <= accn_c;
					tx_q  <= tx_c;
					if (prod_q == P_XY)
						state_q <= S_POST2;
					else
						state_q <= S_SSAT;
				end
				S_SSAT: begin
					if (prod_q == P_SX) begin
						x_q     <= sadd(center_real_q, ts_c);
						neg_q   <= sdy_q;
						prod_q  <= P_SY;
						k_q     <= 3'd0;
						pv_q    <= 1'b0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end else begin
						y_q     <= sadd(center_imag_q, ts_c);
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					ax_q  <= x_q[63] ? (~x_q + 64'd1) : x_q;
					ay_q  <= y_q[63] ? (~y_q + 64'd1) : y_q;
					sxy_q <= x_q[63] ^ y_q[63];
					if (cnt_q == limit_q) begin
						state_q <= S_DONE;
					end else begin
						prod_q  <= P_XX;
						k_q     <= 3'd0;
						pv_q    <= 1'b0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_SAVE: begin
					x2_q    <= acc_q;
					prod_q  <= P_YY;
					k_q     <= 3'd0;
					pv_q    <= 1'b0;
					acc_q   <= '0;
					state_q <= S_MUL;
				end
				S_TEST: begin
					// acc holds |y|^2 here
					x2_q <= x2_q - acc_q;
					if (m_c > BOUND) begin
						state_q <= S_DONE;
					end else begin
						neg_q   <= sxy_q;
						prod_q  <= P_XY;
						k_q     <= 3'd0;
						pv_q    <= 1'b0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_POST2: begin
					ty_q    <= ty_c;
					x_q     <= sadd(tx_q, julia_real_q);
					state_q <= S_POST3;
				end
				S_POST3: begin
					y_q     <= sadd(ty_q, julia_imag_q);
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_ABS;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						oc_q    <= col_q;
						or_q    <= row_q;
						ocnt_q  <= cnt_ext[COUNT_W-1:0];
						oesc_q  <= (cnt_q < limit_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{PADW{1'b0}}, oesc_q, ocnt_q, or_q, oc_q};

endmodule

@@ test/testbench.sv @@
module testbench;
	import jetp_pkg::*;

	localparam int PIX_W   = $clog2(DEF_MAX_DIM);
	localparam int PIX_MAX = (1 << PIX_W) - 1;
	localparam int REQ_W   = ((2 * PIX_W + PASS_W + 7) / 8) * 8;
	localparam int RES_W   = ((2 * PIX_W + COUNT_W + 1 + 7) / 8) * 8;
	localparam int FRAC    = DEF_FRAC_BITS;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
	// |z|^2 bound of 4 at the scale of a full-width square
	localparam logic [128:0] RADIUS_SQ = 129'd1 << (2 * FRAC + 2);

	typedef struct packed {
		logic [PASS_W-1:0] pass;
		logic [PIX_W-1:0]  row;
		logic [PIX_W-1:0]  col;
	} pixel_req_t;

	typedef struct packed {
		logic               escaped;
		logic [COUNT_W-1:0] count;
		logic [PIX_W-1:0]   row;
		logic [PIX_W-1:0]   col;
	} pixel_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	// pixel_column, pixel_row, pass_index, zero fill
	logic [REQ_W-1:0] s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// out_column, out_row, escape_count, escaped, zero fill
	logic [RES_W-1:0] m_tdata;

	julia_escape_time_pixel u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// view and Julia constant as the block should hold them
	logic signed [63:0] view_re, view_im, c_re, c_im;
	logic [62:0]        pitch;
	logic [12:0]        img_w, img_h;

	pixel_req_t pixel_backlog[$];
	pixel_res_t predicted_results[$];

	int pixels_queued = 0;
	int results_checked = 0;
	int mismatches = 0;
	int n_escaped = 0;
	int n_at_limit = 0;
	int longest_orbit = 0;
	int backpressure_cycles = 0;
	int n_views = 1;

	initial forever #2 clk = ~clk;

	function automatic logic signed [127:0] widen(input logic signed [63:0] v);
		return v;
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
		if (v[127:63] == '0 || v[127:63] == '1)
			return v[63:0];
		return v[127] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp64(widen(a) + widen(b));
	endfunction

	function automatic logic signed [63:0] start_point(input logic signed [63:0] center,
			input logic [PIX_W-1:0] pix, input logic [12:0] size);
		logic signed [127:0] offset;
		logic signed [127:0] step;
		offset = widen(64'(pix)) - widen(64'(size >> 1));
		step = widen({1'b0, pitch});
		return add_sat(center, clamp64(offset * step));
	endfunction

	function automatic pixel_res_t escape_time(input pixel_req_t req);
		logic signed [63:0]  zr, zi;
		logic signed [127:0] rr, ii, ri;
		logic [PASS_W-1:0]   stage;
		int unsigned         limit, n;
		pixel_res_t          res;
		stage = (req.pass >= DEF_PASS_COUNT) ? PASS_W'(DEF_PASS_COUNT - 1) : req.pass;
		limit = LIMIT_BASE << stage;
		zr = start_point(view_re, req.col, img_w);
		zi = start_point(view_im, req.row, img_h);
		n = 0;
		while (n < limit) begin
			rr = widen(zr) * widen(zr);
			ii = widen(zi) * widen(zi);
			if ({1'b0, rr} + {1'b0, ii} > RADIUS_SQ)
				break;
			ri = widen(zr) * widen(zi);
			// floor shift; one bit less on the cross term doubles it
			zr = add_sat(clamp64((rr - ii) >>> FRAC), c_re);
			zi = add_sat(clamp64(ri >>> (FRAC - 1)), c_im);
			n++;
		end
		res.col = req.col;
		res.row = req.row;
		res.count = COUNT_W'(n);
		res.escaped = (n < limit);
		return res;
	endfunction

	function automatic logic signed [63:0] rand_unit();
		logic signed [63:0] r;
		r = {32'd0, $urandom};
		return (r - 64'sh8000_0000) <<< (FRAC - 31);
	endfunction

	function automatic int pick_pass();
		int unsigned k;
		k = $urandom_range(0, 99);
		// keep long orbits rare so the run stays short
		if (k < 40) return 0;
		if (k < 65) return 1;
		if (k < 80) return 2;
		if (k < 90) return 3;
		if (k < 95) return 4;
		return $urandom_range(5, 7);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic check_pixel(input pixel_res_t got);
		pixel_res_t want;
		string      tag;
		if (predicted_results.size() == 0) begin
			flag_mismatch("result with no request outstanding, data", 0, got);
			return;
		end
		want = predicted_results.pop_front();
		results_checked++;
		tag = $sformatf("pixel (%0d,%0d)", want.col, want.row);
		if (got.col != want.col)
			flag_mismatch({tag, " column"}, want.col, got.col);
		if (got.row != want.row)
			flag_mismatch({tag, " row"}, want.row, got.row);
		if (got.count != want.count)
			flag_mismatch({tag, " escape count"}, want.count, got.count);
		if (got.escaped != want.escaped)
			flag_mismatch({tag, " escaped flag"}, want.escaped, got.escaped);
		if (want.escaped)
			n_escaped++;
		else
			n_at_limit++;
		if (want.count > longest_orbit)
			longest_orbit = want.count;
	endtask

	// request source: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive_pixels
		pixel_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && !s_tready)
				backpressure_cycles++;
			if (s_tvalid && s_tready) begin
				req = s_tdata[2 * PIX_W + PASS_W - 1:0];
				predicted_results.push_back(escape_time(req));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					req = pixel_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= REQ_W'(req);
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: stall pattern is redrawn periodically from four modes, plus two long hold-offs
	int hold_left = 0;
	int stall_mode = 0;
	int stall_tick = 0;

	always @(posedge clk or negedge arst_n) begin : take_results
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_pixel(m_tdata[2 * PIX_W + COUNT_W:0]);
				if (results_checked == 150 || results_checked == 1200)
					hold_left = 6000;
			end
			stall_tick++;
			if (stall_tick % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= stall_tick[0];
				endcase
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CENTER_REAL:  view_re = value;
			REG_CENTER_IMAG:  view_im = value;
			REG_STEP_SCALE:   pitch = value[62:0];
			REG_IMAGE_WIDTH:  img_w = value[12:0];
			REG_IMAGE_HEIGHT: img_h = value[12:0];
			REG_JULIA_REAL:   c_re = value;
			REG_JULIA_IMAG:   c_im = value;
			default: ;
		endcase
	endtask

	task automatic load_view(input logic [63:0] cr, input logic [63:0] ci,
			input logic [63:0] step, input logic [63:0] w, input logic [63:0] h,
			input logic [63:0] jr, input logic [63:0] ji);
		write_reg(REG_CENTER_REAL, cr);
		write_reg(REG_CENTER_IMAG, ci);
		write_reg(REG_STEP_SCALE, step);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_JULIA_REAL, jr);
		write_reg(REG_JULIA_IMAG, ji);
		n_views++;
	endtask

	task automatic queue_pixel(input int col, input int row, input int pass);
		pixel_req_t req;
		req.col = PIX_W'(col);
		req.row = PIX_W'(row);
		req.pass = PASS_W'(pass);
		pixel_backlog.push_back(req);
		pixels_queued++;
	endtask

	task automatic queue_random_pixels(input int count);
		int span_w, span_h;
		span_w = (img_w == 0) ? 1 : ((img_w > PIX_MAX + 1) ? PIX_MAX + 1 : img_w);
		span_h = (img_h == 0) ? 1 : ((img_h > PIX_MAX + 1) ? PIX_MAX + 1 : img_h);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				queue_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX), pick_pass());
			else
				queue_pixel($urandom_range(0, span_w - 1), $urandom_range(0, span_h - 1),
					pick_pass());
		end
	endtask

	// hold until every request has its result, then let the block go quiet
	task automatic settle(input int cycles);
		while (results_checked != pixels_queued)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	initial begin : run_views
		int w, h;
		view_re = RST_CENTER_REAL;
		view_im = RST_CENTER_IMAG;
		pitch = RST_STEP_SCALE;
		img_w = 13'(RST_IMAGE_WIDTH);
		img_h = 13'(RST_IMAGE_HEIGHT);
		c_re = RST_JULIA_REAL;
		c_im = RST_JULIA_IMAG;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset view: the image center maps to z = 0; try every pass there
		for (int p = 0; p < 8; p++)
			queue_pixel(512, 384, p);
		queue_pixel(0, 0, 0);
		queue_pixel(PIX_MAX, PIX_MAX, 5);
		queue_pixel(PIX_MAX, 0, 1);
		queue_pixel(0, PIX_MAX, 2);
		queue_pixel(12'hAAA, 12'h555, 3);
		queue_pixel(12'h555, 12'hAAA, 4);
		queue_pixel(511, 383, 5);
		queue_random_pixels(210);
		settle(50);

		// small image zoomed onto a connected set with a large interior
		load_view(0, 0, ONE >>> 6 * 3, 64, 48, -(ONE * 4) / 10, (ONE * 6) / 10);
		queue_random_pixels(240);
		settle(50);

		// everything saturates; width write has only bits above the register set
		load_view(SAT_MAX, SAT_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_E000,
			64'd8191, SAT_MIN, SAT_MAX);
		queue_pixel(0, 0, 5);
		queue_pixel(PIX_MAX, PIX_MAX, 0);
		queue_random_pixels(200);
		settle(50);

		// zero step and zero height: every pixel starts from the same point
		load_view(rand_unit(), rand_unit(), 0, 1, 0, rand_unit(), rand_unit());
		queue_random_pixels(200);
		settle(50);

		// start points inside the radius, constant at the extremes
		load_view(0, 0, ONE >>> 11, 4096, 4096, SAT_MAX, SAT_MIN);
		queue_random_pixels(200);
		settle(50);

		for (int v = 0; v < 3; v++) begin
			w = ($urandom_range(0, 2) == 0) ? $urandom_range(64, 4096) : $urandom_range(1, 64);
			h = ($urandom_range(0, 2) == 0) ? $urandom_range(64, 4096) : $urandom_range(1, 64);
			load_view(rand_unit() + (rand_unit() >>> 1), rand_unit() >>> 1,
				(ONE >>> 6) * $urandom_range(1, 256) / w, w, h,
				rand_unit() - (rand_unit() >>> 2), rand_unit() - (rand_unit() >>> 2));
			queue_random_pixels(250);
			settle(50);
		end

		settle(4200);
		$display("%0d pixels checked over %0d views: %0d escaped, %0d reached the pass limit",
			results_checked, n_views, n_escaped, n_at_limit);
		$display("longest orbit %0d iterations; requests held back by the block for %0d cycles",
			longest_orbit, backpressure_cycles);
		if (mismatches == 0) begin
			$display("julia_escape_time_pixel regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("julia_escape_time_pixel regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#200000000;
		$display("timed out with %0d of %0d results in", results_checked, pixels_queued);
		$display("julia_escape_time_pixel regression: fail");
		$finish;
	end

endmodule
